// ----- hw/rtl/plc_pkg.sv -----
// ----------------------------------------------------------------------------
// plc_pkg
// Shared types and constants for the positional list store: operation and
// status codes, the cell shift command and the request/response payloads.
// ----------------------------------------------------------------------------
package plc_pkg;

   localparam int CAPACITY_DEF = 16;

   typedef enum logic [2:0] {
      FN_READ   = 3'd0,
      FN_FIND   = 3'd1,
      FN_INSERT = 3'd2,
      FN_DELETE = 3'd3,
      FN_CLEAR  = 3'd4
   } func_type;

   typedef enum logic [1:0] {
      ST_OK     = 2'd0,
      ST_BADPOS = 2'd1,
      ST_FULL   = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      SH_HOLD   = 2'd0,
      SH_INSERT = 2'd1,
      SH_DELETE = 2'd2
   } shift_type;

   // Broadcast to every cell of the chain
   typedef struct packed {
      shift_type   op;
      logic [4:0]  slot;
      logic [7:0]  value;
   } ctrl_type;

   typedef struct packed {
      logic [2:0] func;
      logic [4:0] position;
      logic [7:0] value;
   } req_type;

   typedef struct packed {
      logic [1:0] status;
      logic [7:0] data;
      logic [4:0] found_at;
      logic [4:0] length;
      logic       empty_res;
   } rsp_type;

endpackage

// ----- hw/rtl/plc_cell.sv -----
// ----------------------------------------------------------------------------
// plc_cell
// One element slot of the list chain: holds a byte, takes the new value or its
// left neighbour's byte on insert, its right neighbour's on delete, and flags a
// match against the search value while it lies below the current length.
// ----------------------------------------------------------------------------
module plc_cell #(
   parameter int INDEX = 0,
   parameter int CNT_W = 5
) (
   input  logic                clock,
   input  plc_pkg::ctrl_type   ctrl,
   input  logic [CNT_W-1:0]    count,
   input  logic [7:0]          left_data,
   input  logic [7:0]          right_data,
   output logic [7:0]          data_out,
   output logic                hit
);

   logic [7:0] data_ff;
   logic [7:0] data_in;
   logic       at_slot;
   logic       past_slot;
   logic       occupied;

   assign at_slot   = (INDEX == int'(ctrl.slot));
   assign past_slot = (INDEX >  int'(ctrl.slot));
   assign occupied  = (INDEX <  int'(count));

   always_comb begin
      data_in = data_ff;
      case (ctrl.op)
         plc_pkg::SH_INSERT: begin
            if (at_slot) begin
               data_in = ctrl.value;
            end else if (past_slot) begin
               data_in = left_data;
            end
         end
         plc_pkg::SH_DELETE: begin
            if (at_slot || past_slot) begin
               data_in = right_data;
            end
         end
         default: begin
            data_in = data_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data_out = data_ff;
   assign hit      = occupied && (data_ff == ctrl.value);

endmodule

// ----- hw/rtl/positional_list_store.sv -----
// The response is registered and appears in the cycle after the request
// transaction is accepted.
// One transaction per cycle unless a held response stalls the request side;
// each operation is one pass over the cells, all shifting or comparing at once.
// Reset clears the element count and the response valid; element bytes are
// not reset and are only read below the count.
// ----------------------------------------------------------------------------
// positional_list_store
// Ordered byte list addressed by 1-based position: read, find, insert,
// delete and clear, held in a chain of shifting cells.
// ----------------------------------------------------------------------------
module positional_list_store #(
   parameter int CAPACITY = plc_pkg::CAPACITY_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  plc_pkg::req_type  req_payload,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output plc_pkg::rsp_type  rsp_payload
);

   localparam int CntW = $clog2(CAPACITY + 1);
   localparam int IdxW = $clog2(CAPACITY);
   localparam int CmpW = ((CntW > 5) ? CntW : 5) + 1;

   logic [CntW-1:0]   count_ff;
   logic [CntW-1:0]   count_in;
   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   plc_pkg::rsp_type  rsp_ff;
   plc_pkg::rsp_type  rsp_in;
   plc_pkg::ctrl_type ctrl;

   logic [7:0]        cell_data [CAPACITY];
   logic [CAPACITY-1:0] hit;

   logic              accept;
   logic [CmpW-1:0]   pos_ext;
   logic [CmpW-1:0]   cnt_ext;
   logic              rd_ok;
   logic              ins_ok;
   logic              full;
   logic [4:0]        pos_m1;
   logic [IdxW-1:0]   rd_idx;
   logic [7:0]        rd_data;
   logic [4:0]        found;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   assign pos_ext = CmpW'(req_payload.position);
   assign cnt_ext = CmpW'(count_ff);
   assign rd_ok   = (req_payload.position != 5'd0) && (pos_ext <= cnt_ext);
   assign ins_ok  = (req_payload.position != 5'd0) && (pos_ext <= cnt_ext + CmpW'(1));
   assign full    = (cnt_ext == CmpW'(CAPACITY));
   assign pos_m1  = req_payload.position - 5'd1;
   assign rd_idx  = IdxW'(pos_m1);
   assign rd_data = rd_ok ? cell_data[rd_idx] : 8'd0;

   // Cell command: shift only on an accepted, legal insert or delete
   always_comb begin
      ctrl.op    = plc_pkg::SH_HOLD;
      ctrl.slot  = pos_m1;
      ctrl.value = req_payload.value;
      if (accept) begin
         if (req_payload.func == plc_pkg::FN_INSERT && ins_ok && !full) begin
            ctrl.op = plc_pkg::SH_INSERT;
         end else if (req_payload.func == plc_pkg::FN_DELETE && rd_ok) begin
            ctrl.op = plc_pkg::SH_DELETE;
         end
      end
   end

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [7:0] left_data;
      logic [7:0] right_data;
      if (i == 0) begin : g_first
         assign left_data = 8'd0;
      end else begin : g_mid_l
         assign left_data = cell_data[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
         assign right_data = 8'd0;
      end else begin : g_mid_r
         assign right_data = cell_data[i+1];
      end
      plc_cell #(
         .INDEX (i),
         .CNT_W (CntW)
      ) u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .count      (count_ff),
         .left_data  (left_data),
         .right_data (right_data),
         .data_out   (cell_data[i]),
         .hit        (hit[i])
      );
   end

   // First matching position wins
   always_comb begin
      found = 5'd0;
      for (int i = CAPACITY - 1; i >= 0; i--) begin
         if (hit[i]) begin
            found = 5'(i + 1);
         end
      end
   end

   always_comb begin
      count_in        = count_ff;
      rsp_in.status   = plc_pkg::ST_OK;
      rsp_in.data     = 8'd0;
      rsp_in.found_at = 5'd0;
      case (req_payload.func)
         plc_pkg::FN_READ: begin
            if (rd_ok) begin
               rsp_in.data = rd_data;
            end else begin
               rsp_in.status = plc_pkg::ST_BADPOS;
            end
         end
         plc_pkg::FN_FIND: begin
            rsp_in.found_at = found;
         end
         plc_pkg::FN_INSERT: begin
            if (!ins_ok) begin
               rsp_in.status = plc_pkg::ST_BADPOS;
            end else if (full) begin
               rsp_in.status = plc_pkg::ST_FULL;
            end else begin
               count_in = count_ff + CntW'(1);
            end
         end
         plc_pkg::FN_DELETE: begin
            if (rd_ok) begin
               rsp_in.data = rd_data;
               count_in    = count_ff - CntW'(1);
            end else begin
               rsp_in.status = plc_pkg::ST_BADPOS;
            end
         end
         plc_pkg::FN_CLEAR: begin
            count_in = '0;
         end
         default: begin
            count_in = count_ff;
         end
      endcase
      rsp_in.length    = 5'(count_in);
      rsp_in.empty_res = (count_in == '0);
   end

   always_comb begin
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            count_ff <= count_in;
         end
      end
   end

   // Payload register, no reset needed
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      CmpW'(count_ff) <= CmpW'(CAPACITY))
      else $error("element count above capacity");

   a_clear_empties : assert property (@(posedge clock) disable iff (reset)
      accept && req_payload.func == plc_pkg::FN_CLEAR
      |=> rsp_valid && rsp_payload.empty_res && count_ff == '0)
      else $error("clear left elements behind");

   a_insert_grows : assert property (@(posedge clock) disable iff (reset)
      ctrl.op == plc_pkg::SH_INSERT |=> count_ff == $past(count_ff) + CntW'(1))
      else $error("insert did not grow the list");

   a_delete_shrinks : assert property (@(posedge clock) disable iff (reset)
      ctrl.op == plc_pkg::SH_DELETE |=> count_ff == $past(count_ff) - CntW'(1))
      else $error("delete did not shrink the list");

endmodule
